// File: rtl/cocmc_pkg.sv
// Shared types, register indexes and constants of the clock offset median corrector.
`default_nettype none
package cocmc_pkg;

	localparam int unsigned TIME_W    = 48;
	localparam int unsigned OFF_W     = 40;
	localparam int unsigned USED_W    = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd4;

	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_WEIGHTED = 2'd1;
	localparam logic [1:0] MODE_MEDIAN   = 2'd2;

	localparam logic [1:0]  RST_MODE   = MODE_MEDIAN;
	localparam logic [15:0] RST_GAIN   = 16'd4096;
	localparam logic [7:0]  RST_JUMP   = 8'd1;
	localparam logic [31:0] RST_PERIOD = 32'd1000000;
	localparam logic [31:0] RST_START  = 32'd0;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] arrival_time;
	} cocmc_in_t;

	typedef struct packed {
		logic [TIME_W-1:0]        next_broadcast_time;
		logic [TIME_W-1:0]        next_control_time;
		logic signed [OFF_W-1:0]  applied_offset;
		logic [USED_W-1:0]        samples_used;
	} cocmc_out_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SAMPLE,
		OP_INIT,
		OP_REM,
		OP_RD_I,
		OP_CAND,
		OP_RD_J,
		OP_CMP,
		OP_SEL,
		OP_MED,
		OP_DEV,
		OP_DEN,
		OP_WLOAD,
		OP_DIV,
		OP_MUL,
		OP_ACC,
		OP_MEAN,
		OP_WOFF,
		OP_GATE,
		OP_CORR,
		OP_UPD
	} cocmc_op_t;

	typedef struct packed {
		cocmc_op_t op;
	} cocmc_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_lt2;
		logic last_i;
		logic last_j;
		logic rem_last;
		logic div_last;
		logic s_zero;
		logic mode_weighted;
	} cocmc_status_t;

endpackage
`default_nettype wire

// File: rtl/cocmc_datapath.sv
// Datapath: configuration registers, offset store, rank selection, weighting and deadline update.
`default_nettype none
module cocmc_datapath import cocmc_pkg::*; #(
	parameter int unsigned MAX_NEIGHBOURS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
	input  wire logic [TIME_W-1:0]     arrival_time,
	input  wire cocmc_cmd_t            cmd,
	output cocmc_status_t              status,
	output cocmc_out_t                 result,
	output logic                       result_valid
);

	localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1);
	localparam int unsigned AW = $clog2(MAX_NEIGHBOURS);
	localparam int unsigned SW = OFF_W + 1 + CW;
	localparam int unsigned DW = SW + CW;

	// Configuration and persistent state.
	logic [1:0]         mode_q;
	logic [15:0]        gain_q;
	logic [7:0]         jump_q;
	logic [31:0]        period_q;
	logic [TIME_W-1:0]  bd_q;
	logic [TIME_W-1:0]  cd_q;
	logic [31:0]        pidx_q;
	logic [CW-1:0]      cnt_q;

	logic signed [OFF_W-1:0] mem [MAX_NEIGHBOURS];
	logic signed [OFF_W-1:0] rdata_q;
	logic [AW-1:0]           raddr;

	// Working registers of one period tick.
	logic [CW-1:0]           n_q, i_q, j_q, lt_q, le_q, k1_q, k2_q;
	logic signed [OFF_W-1:0] cand_q, m1_q, m2_q, med_q, off_q, v_q;
	logic [31:0]             pidx_sh_q;
	logic [7:0]              rem_q, dvs_q;
	logic [4:0]              rcnt_q;
	logic [3:0]              dcnt_q;
	logic [SW-1:0]           s_q;
	logic [DW-1:0]           den_q;
	logic [DW:0]             r_q;
	logic [16:0]             q_q;
	logic signed [57:0]      prod_q;
	logic signed [63:0]      acc_q;
	logic signed [58:0]      mprod_q;
	logic signed [56:0]      cprod_q;

	logic signed [TIME_W:0]  samp_diff;
	logic signed [OFF_W-1:0] samp_off;
	logic                    samp_wr;
	logic signed [OFF_W:0]   med_sum;
	logic signed [OFF_W-1:0] med_c;
	logic signed [OFF_W:0]   dev_s;
	logic [OFF_W:0]          dev_c;
	logic [SW-1:0]           num_c;
	logic [DW:0]             r2_c;
	logic [8:0]              rem_t;
	logic [46:0]             woff_sh;
	logic signed [OFF_W-1:0] woff_c;
	logic signed [44:0]      corr_c;
	logic [TIME_W-1:0]       corr48;
	logic [TIME_W-1:0]       nb_c, nc_c;
	logic [CW-1:0]           half_c;

	// Offset of a sample, saturated to the signed offset range.
	assign samp_diff = $signed({1'b0, bd_q}) - $signed({1'b0, arrival_time});
	always_comb begin
		if (!samp_diff[TIME_W] && (samp_diff[TIME_W-1:OFF_W-1] != '0)) begin
			samp_off = {1'b0, {(OFF_W-1){1'b1}}};
		end else if (samp_diff[TIME_W] && (samp_diff[TIME_W-1:OFF_W-1] != '1)) begin
			samp_off = {1'b1, {(OFF_W-1){1'b0}}};
		end else begin
			samp_off = samp_diff[OFF_W-1:0];
		end
	end
	assign samp_wr = (cmd.op == OP_SAMPLE) && (cnt_q < CW'(MAX_NEIGHBOURS));

	assign raddr = (cmd.op == OP_RD_J) ? j_q[AW-1:0] : i_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (samp_wr) begin
			mem[cnt_q[AW-1:0]] <= samp_off;
		end
		rdata_q <= mem[raddr];
	end

	assign med_sum = $signed({m1_q[OFF_W-1], m1_q}) + $signed({m2_q[OFF_W-1], m2_q});
	assign med_c   = (n_q == '0) ? '0 : med_sum[OFF_W:1];

	assign dev_s = $signed({rdata_q[OFF_W-1], rdata_q}) - $signed({med_q[OFF_W-1], med_q});
	assign dev_c = dev_s[OFF_W] ? (OFF_W+1)'(-dev_s) : dev_s;
	assign num_c = s_q - SW'(dev_c);
	assign r2_c  = {r_q[DW-1:0], 1'b0};

	assign rem_t = {rem_q, pidx_sh_q[31]};

	assign woff_sh = mprod_q[58:12];
	always_comb begin
		if (!woff_sh[46] && (woff_sh[45:OFF_W-1] != '0)) begin
			woff_c = {1'b0, {(OFF_W-1){1'b1}}};
		end else if (woff_sh[46] && (woff_sh[45:OFF_W-1] != '1)) begin
			woff_c = {1'b1, {(OFF_W-1){1'b0}}};
		end else begin
			woff_c = woff_sh[OFF_W-1:0];
		end
	end

	assign corr_c = cprod_q[56:12];
	assign corr48 = {{(TIME_W-45){corr_c[44]}}, corr_c};
	assign nb_c   = bd_q - corr48 + {16'd0, period_q};
	assign nc_c   = cd_q - corr48 + {16'd0, period_q};
	assign half_c = cnt_q >> 1;

	always_comb begin
		status.n_zero        = (n_q == '0);
		status.n_lt2         = (n_q < CW'(2));
		status.last_i        = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(n_q);
		status.last_j        = ((CW+1)'(j_q) + (CW+1)'(1)) == (CW+1)'(n_q);
		status.rem_last      = (rcnt_q == 5'd31);
		status.div_last      = (dcnt_q == 4'd15);
		status.s_zero        = (s_q == '0);
		status.mode_weighted = (mode_q == MODE_WEIGHTED);
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			gain_q       <= RST_GAIN;
			jump_q       <= RST_JUMP;
			period_q     <= RST_PERIOD;
			bd_q         <= {16'd0, RST_START};
			cd_q         <= {16'd0, RST_START} + {17'd0, RST_PERIOD[31:1]};
			pidx_q       <= 32'd1;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (cmd.op == OP_UPD);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:   mode_q   <= cfg_wdata[1:0];
					CFG_GAIN:   gain_q   <= cfg_wdata[15:0];
					CFG_JUMP:   jump_q   <= cfg_wdata[7:0];
					CFG_PERIOD: period_q <= cfg_wdata;
					CFG_START: begin
						bd_q <= {16'd0, cfg_wdata};
						cd_q <= {16'd0, cfg_wdata} + {17'd0, period_q[31:1]};
					end
					default: ;
				endcase
			end
			if (samp_wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.op == OP_UPD) begin
				bd_q   <= nb_c;
				cd_q   <= nc_c;
				pidx_q <= pidx_q + 32'd1;
				cnt_q  <= '0;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_INIT: begin
				n_q       <= cnt_q;
				pidx_sh_q <= pidx_q;
				rem_q     <= '0;
				rcnt_q    <= '0;
				dvs_q     <= (jump_q == '0) ? 8'd1 : jump_q;
				i_q       <= '0;
				m1_q      <= '0;
				m2_q      <= '0;
				k1_q      <= (cnt_q == CW'(1)) ? '0 : half_c - CW'(1);
				k2_q      <= (cnt_q == CW'(1)) ? '0 : half_c;
			end
			OP_REM: begin
				rem_q     <= (rem_t >= {1'b0, dvs_q}) ? 8'(rem_t - {1'b0, dvs_q}) : rem_t[7:0];
				pidx_sh_q <= pidx_sh_q << 1;
				rcnt_q    <= rcnt_q + 5'd1;
			end
			OP_CAND: begin
				cand_q <= rdata_q;
				j_q    <= '0;
				lt_q   <= '0;
				le_q   <= '0;
			end
			OP_CMP: begin
				lt_q <= lt_q + CW'(rdata_q < cand_q);
				le_q <= le_q + CW'(rdata_q <= cand_q);
				j_q  <= j_q + CW'(1);
			end
			OP_SEL: begin
				// The candidate has rank k when k lies in [count below, count at or below).
				if ((lt_q <= k1_q) && (k1_q < le_q)) begin
					m1_q <= cand_q;
				end
				if ((lt_q <= k2_q) && (k2_q < le_q)) begin
					m2_q <= cand_q;
				end
				i_q <= i_q + CW'(1);
			end
			OP_MED: begin
				med_q <= med_c;
				off_q <= (mode_q == MODE_MEDIAN) ? med_c : '0;
				i_q   <= '0;
				s_q   <= '0;
			end
			OP_DEV: begin
				s_q <= s_q + SW'(dev_c);
				i_q <= i_q + CW'(1);
			end
			OP_DEN: begin
				den_q <= (n_q - CW'(1)) * s_q;
				i_q   <= '0;
				acc_q <= '0;
			end
			OP_WLOAD: begin
				v_q    <= rdata_q;
				q_q    <= {16'd0, (DW'(num_c) >= den_q)};
				r_q    <= (DW'(num_c) >= den_q) ? (DW+1)'(DW'(num_c) - den_q) : (DW+1)'(num_c);
				dcnt_q <= '0;
			end
			OP_DIV: begin
				q_q    <= {q_q[15:0], (r2_c >= {1'b0, den_q})};
				r_q    <= (r2_c >= {1'b0, den_q}) ? r2_c - {1'b0, den_q} : r2_c;
				dcnt_q <= dcnt_q + 4'd1;
			end
			OP_MUL: prod_q <= v_q * $signed({1'b0, q_q});
			OP_ACC: begin
				acc_q <= acc_q + 64'(prod_q);
				i_q   <= i_q + CW'(1);
			end
			OP_MEAN: mprod_q <= $signed(acc_q[57:16]) * $signed({1'b0, gain_q});
			OP_WOFF: off_q <= woff_c;
			OP_GATE: begin
				if (rem_q != '0) begin
					off_q <= '0;
				end
			end
			OP_CORR: cprod_q <= off_q * $signed({1'b0, gain_q});
			OP_UPD: begin
				result.next_broadcast_time <= nb_c;
				result.next_control_time   <= nc_c;
				result.applied_offset      <= off_q;
				result.samples_used        <= USED_W'(n_q);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/cocmc_ctrl.sv
// Controller state machine that sequences one period tick through the datapath.
`default_nettype none
module cocmc_ctrl import cocmc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          command,
	input  wire cocmc_status_t status,
	output cocmc_cmd_t         cmd,
	output logic               busy
);

	typedef enum logic [20:0] {
		ST_IDLE   = 21'h000001,
		ST_REM    = 21'h000002,
		ST_SEL_RD = 21'h000004,
		ST_CAND   = 21'h000008,
		ST_CMP_RD = 21'h000010,
		ST_CMP    = 21'h000020,
		ST_SEL    = 21'h000040,
		ST_MED    = 21'h000080,
		ST_DEV_RD = 21'h000100,
		ST_DEV    = 21'h000200,
		ST_DEN    = 21'h000400,
		ST_W_RD   = 21'h000800,
		ST_WLOAD  = 21'h001000,
		ST_DIV    = 21'h002000,
		ST_MUL    = 21'h004000,
		ST_ACC    = 21'h008000,
		ST_MEAN   = 21'h010000,
		ST_WOFF   = 21'h020000,
		ST_GATE   = 21'h040000,
		ST_CORR   = 21'h080000,
		ST_UPD    = 21'h100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_TICK) begin
						cmd.op  = OP_INIT;
						state_d = ST_REM;
					end else begin
						cmd.op = OP_SAMPLE;
					end
				end
			end
			ST_REM: begin
				cmd.op = OP_REM;
				if (status.rem_last) begin
					state_d = status.n_zero ? ST_MED : ST_SEL_RD;
				end
			end
			ST_SEL_RD: begin
				cmd.op  = OP_RD_I;
				state_d = ST_CAND;
			end
			ST_CAND: begin
				cmd.op  = OP_CAND;
				state_d = ST_CMP_RD;
			end
			ST_CMP_RD: begin
				cmd.op  = OP_RD_J;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.op  = OP_CMP;
				state_d = status.last_j ? ST_SEL : ST_CMP_RD;
			end
			ST_SEL: begin
				cmd.op  = OP_SEL;
				state_d = status.last_i ? ST_MED : ST_SEL_RD;
			end
			ST_MED: begin
				cmd.op  = OP_MED;
				state_d = (status.mode_weighted && !status.n_lt2) ? ST_DEV_RD : ST_GATE;
			end
			ST_DEV_RD: begin
				cmd.op  = OP_RD_I;
				state_d = ST_DEV;
			end
			ST_DEV: begin
				cmd.op  = OP_DEV;
				state_d = status.last_i ? ST_DEN : ST_DEV_RD;
			end
			ST_DEN: begin
				cmd.op  = OP_DEN;
				state_d = status.s_zero ? ST_GATE : ST_W_RD;
			end
			ST_W_RD: begin
				cmd.op  = OP_RD_I;
				state_d = ST_WLOAD;
			end
			ST_WLOAD: begin
				cmd.op  = OP_WLOAD;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (status.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = status.last_i ? ST_MEAN : ST_W_RD;
			end
			ST_MEAN: begin
				cmd.op  = OP_MEAN;
				state_d = ST_WOFF;
			end
			ST_WOFF: begin
				cmd.op  = OP_WOFF;
				state_d = ST_GATE;
			end
			ST_GATE: begin
				cmd.op  = OP_GATE;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				cmd.op  = OP_CORR;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.op  = OP_UPD;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/clock_offset_median_corrector_unit.sv
// Top level of the clock offset median corrector: controller, datapath and checks.
//
// A transaction on the request channel is taken at a rising edge with start high and
// busy low. A sample transaction (command 0) stores the offset of the own next
// broadcast time minus the arrival time; busy stays low and no result
// follows, and samples beyond MAX_NEIGHBOURS are dropped. A period tick (command 1)
// raises busy and, when done, shows one result transaction for exactly one cycle
// with result_valid high, in the cycle in which busy falls. The receiver cannot hold it
// off, so the block never waits on the output side.
// A tick keeps busy high until its sequence is done. In the weighted mode with two or
// more offsets it also sums the deviations and then weights each offset, but skips
// the weighting when all offsets are equal. The duration
// is set by the single read port of the offset store: the two middle values
// are found by ranking every entry against all entries, one read per cycle, and each
// weight comes from a divider that makes one quotient bit per cycle. A 32-step
// serial remainder decides whether this period applies its correction.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once. The user makes
// them while the block is idle; the block does not enforce it. Writing the first
// broadcast time reloads both deadlines. Reset (arst_n low) restores the register
// defaults, sets the deadlines from them, empties the store and idles the controller.
`default_nettype none
module clock_offset_median_corrector_unit import cocmc_pkg::*; #(
	parameter int unsigned MAX_NEIGHBOURS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cocmc_in_t            request,
	output cocmc_out_t                result,
	output logic                      result_valid,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	cocmc_cmd_t    cmd;
	cocmc_status_t status;

	// The controller only steps through states; every value lives in the datapath.
	cocmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	cocmc_datapath #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.arrival_time (request.arrival_time),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	// A result only appears once the tick sequence has finished.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while a tick is still running");

	// Each tick gives a single one-cycle result.
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// An accepted tick always starts the sequence.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_TICK)) |=> busy)
		else $error("period tick accepted without raising busy");

	// A sample is absorbed in its own cycle.
	a_sample_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_SAMPLE)) |=> (!busy && !result_valid))
		else $error("sample transaction caused busy or a result");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench of the clock offset median corrector unit.
`timescale 1ns / 1ps
module tb_top import cocmc_pkg::*; ();

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int unsigned STORE_DEPTH = 32;
	localparam int unsigned WATCHDOG_LIMIT = 50000;

	// Tracks the corrector's registers and state, and keeps the result
	// transactions that period ticks are still owed.
	class deadline_scoreboard;
		bit [1:0]            mode;
		bit [15:0]           gain;
		bit [7:0]            jump;
		bit [31:0]           period;
		bit [31:0]           start_t;
		bit [TIME_W-1:0]     bcast;
		bit [TIME_W-1:0]     ctrl;
		bit [31:0]           pidx;
		int unsigned         cnt;
		longint              offsets[STORE_DEPTH];
		cocmc_out_t          due[$];
		int                  errors;

		function new();
			mode = RST_MODE;
			gain = RST_GAIN;
			jump = RST_JUMP;
			period = RST_PERIOD;
			start_t = RST_START;
			reload();
			pidx = 1;
			cnt = 0;
			errors = 0;
		endfunction

		function void reload();
			bcast = {16'd0, start_t};
			ctrl = {16'd0, start_t} + {17'd0, period[31:1]};
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
			case (idx)
				CFG_MODE: mode = v[1:0];
				CFG_GAIN: gain = v[15:0];
				CFG_JUMP: jump = v[7:0];
				CFG_PERIOD: period = v;
				CFG_START: begin
					start_t = v;
					reload();
				end
				default: ;
			endcase
		endfunction

		function longint clamp40(longint x);
			if (x > 64'sd549755813887)
				return 64'sd549755813887;
			if (x < -64'sd549755813888)
				return -64'sd549755813888;
			return x;
		endfunction

		// A sample only fills the store; a tick computes the next deadlines.
		function void note_input(cocmc_in_t it);
			longint d, v, med, off, corr, acc, mean, g;
			longint unsigned devs[STORE_DEPTH];
			longint unsigned s, den, w;
			int n, i, j;
			bit [31:0] jmp;
			cocmc_out_t r;
			if (it.command == CMD_SAMPLE) begin
				if (cnt < STORE_DEPTH) begin
					d = longint'({16'd0, bcast}) - longint'({16'd0, it.arrival_time});
					offsets[cnt] = clamp40(d);
					cnt++;
				end
				return;
			end
			n = cnt;
			for (i = 1; i < n; i++) begin
				v = offsets[i];
				j = i;
				while (j > 0 && offsets[j-1] > v) begin
					offsets[j] = offsets[j-1];
					j--;
				end
				offsets[j] = v;
			end
			if (n == 0)
				med = 0;
			else if (n == 1)
				med = offsets[0];
			else
				med = (offsets[n/2-1] + offsets[n/2]) >>> 1;
			g = longint'({48'd0, gain});
			off = 0;
			if (mode == MODE_MEDIAN) begin
				off = med;
			end else if (mode == MODE_WEIGHTED) begin
				s = 0;
				for (i = 0; i < n; i++) begin
					v = offsets[i] - med;
					devs[i] = (v < 0) ? longint'(-v) : longint'(v);
					s += devs[i];
				end
				if (s != 0 && n >= 2) begin
					// Weights are fractions with 16 fraction bits.
					den = longint'(n - 1) * s;
					acc = 0;
					for (i = 0; i < n; i++) begin
						w = ((s - devs[i]) << 16) / den;
						acc += offsets[i] * longint'(w);
					end
					mean = acc >>> 16;
					off = clamp40((mean * g) >>> 12);
				end
			end
			jmp = (jump == 0) ? 32'd1 : {24'd0, jump};
			if (pidx % jmp != 0)
				off = 0;
			corr = (off * g) >>> 12;
			bcast = bcast - corr[TIME_W-1:0] + period;
			ctrl = ctrl - corr[TIME_W-1:0] + period;
			pidx++;
			cnt = 0;
			r.next_broadcast_time = bcast;
			r.next_control_time = ctrl;
			r.applied_offset = off[OFF_W-1:0];
			r.samples_used = n[USED_W-1:0];
			due.push_back(r);
		endfunction

		function void check_result(cocmc_out_t got);
			cocmc_out_t exp_r;
			if (due.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			exp_r = due.pop_front();
			if (got.next_broadcast_time !== exp_r.next_broadcast_time) begin
				$error("next_broadcast_time: expected %0d, got %0d",
					exp_r.next_broadcast_time, got.next_broadcast_time);
				errors++;
			end
			if (got.next_control_time !== exp_r.next_control_time) begin
				$error("next_control_time: expected %0d, got %0d",
					exp_r.next_control_time, got.next_control_time);
				errors++;
			end
			if (got.applied_offset !== exp_r.applied_offset) begin
				$error("applied_offset: expected %0d, got %0d",
					exp_r.applied_offset, got.applied_offset);
				errors++;
			end
			if (got.samples_used !== exp_r.samples_used) begin
				$error("samples_used: expected %0d, got %0d",
					exp_r.samples_used, got.samples_used);
				errors++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cocmc_in_t            request;
	cocmc_out_t           result;
	logic                 result_valid;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	deadline_scoreboard sb;
	int unsigned accepted;
	int unsigned quiet_cycles;
	int unsigned items_sent;
	bit          no_gaps;
	longint      last_offset;

	clock_offset_median_corrector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result(result),
		.result_valid(result_valid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Monitor: everything is sampled at the rising edge, before the block's
	// own updates land. Request and result transactions both feed the
	// scoreboard, and the watchdog counts cycles in which neither happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_input(request);
				accepted++;
			end
			if (result_valid)
				sb.check_result(result);
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Drives one request transaction; called and returning at a falling edge.
	task automatic send(cocmc_in_t it);
		int unsigned seen;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			request.command = 1'($urandom);
			request.arrival_time = TIME_W'({$urandom, $urandom});
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		request = it;
		start = 1'b1;
		seen = accepted;
		do @(negedge clk); while (accepted == seen);
		start = 1'b0;
		items_sent++;
	endtask

	task automatic send_tick();
		cocmc_in_t it;
		it.command = CMD_TICK;
		it.arrival_time = TIME_W'({$urandom, $urandom});
		send(it);
	endtask

	// The arrival time is derived from the deadline that the block will use,
	// so the stored offset is the one we want.
	task automatic send_offset(longint off);
		cocmc_in_t it;
		it.command = CMD_SAMPLE;
		it.arrival_time = sb.bcast - off[TIME_W-1:0];
		send(it);
	endtask

	task automatic send_arrival(logic [TIME_W-1:0] t);
		cocmc_in_t it;
		it.command = CMD_SAMPLE;
		it.arrival_time = t;
		send(it);
	endtask

	// Register writes happen only with nothing in flight.
	task automatic wait_idle();
		while (sb.pending() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly small offsets around the own deadline, sometimes a repeat of the
	// previous one (equal offsets give a zero deviation sum), sometimes a
	// completely random arrival that saturates the stored offset.
	task automatic send_random_sample();
		int kind;
		int sh;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_arrival(TIME_W'({$urandom, $urandom}));
		end else if (kind == 1) begin
			send_offset(last_offset);
		end else begin
			sh = $urandom_range(2, 36);
			last_offset = longint'($urandom_range(0, 1 << 30)) % (64'sd1 << sh);
			if ($urandom_range(0, 1))
				last_offset = -last_offset;
			send_offset(last_offset);
		end
	endtask

	task automatic set_phase(int p);
		case (p)
			0: begin
				write_reg(CFG_MODE, CFG_DAT_W'(MODE_WEIGHTED));
				write_reg(CFG_GAIN, 32'd4096);
				write_reg(CFG_JUMP, 32'd1);
			end
			1: write_reg(CFG_MODE, CFG_DAT_W'(MODE_OFF));
			// The unused mode code must behave as no correction.
			2: write_reg(CFG_MODE, 32'd3);
			3: begin
				write_reg(CFG_MODE, CFG_DAT_W'(MODE_MEDIAN));
				write_reg(CFG_GAIN, 32'd0);
			end
			4: begin
				write_reg(CFG_MODE, CFG_DAT_W'(MODE_WEIGHTED));
				write_reg(CFG_GAIN, 32'd65535);
			end
			5: begin
				write_reg(CFG_MODE, CFG_DAT_W'(MODE_MEDIAN));
				write_reg(CFG_GAIN, 32'd4096);
				write_reg(CFG_JUMP, 32'd0);
			end
			6: write_reg(CFG_JUMP, 32'd255);
			7: begin
				write_reg(CFG_JUMP, 32'd3);
				write_reg(CFG_PERIOD, 32'd1);
			end
			8: begin
				write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
				write_reg(CFG_START, 32'hFFFF_FFFF);
			end
			9: begin
				write_reg(CFG_PERIOD, 32'd1000000);
				write_reg(CFG_START, 32'd0);
				write_reg(CFG_SPARE, $urandom);
			end
			default: begin
				write_reg(CFG_MODE, $urandom_range(0, 3));
				write_reg(CFG_GAIN, $urandom_range(0, 1) ? 32'd4096 : $urandom_range(0, 65535));
				write_reg(CFG_JUMP, $urandom_range(0, 4));
				write_reg(CFG_PERIOD, $urandom);
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_START, $urandom);
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_SPARE, $urandom);
			end
		endcase
	endtask

	initial begin
		int p;
		int k;
		int n;
		sb = new();
		accepted = 0;
		quiet_cycles = 0;
		items_sent = 0;
		no_gaps = 1'b0;
		last_offset = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset settings: empty store, one sample, arrival
		// extremes (the all-ones one saturates), and an even count for the median.
		send_tick();
		send_offset(-5);
		send_tick();
		send_arrival('0);
		send_arrival('1);
		send_tick();
		send_offset(3);
		send_offset(-7);
		send_offset(10);
		send_offset(2);
		send_tick();
		wait_idle();
		write_reg(CFG_MODE, CFG_DAT_W'(MODE_WEIGHTED));
		send_offset(4);
		send_offset(-4);
		send_offset(10);
		send_tick();
		send_offset(6);
		send_offset(6);
		send_tick();
		send_offset(-1000);
		send_tick();

		// Random part: phases of settings, each a run of periods with a
		// random number of samples, now and then more than the store holds.
		p = 0;
		while (items_sent < 640) begin
			wait_idle();
			set_phase(p);
			p++;
			k = 0;
			while (k < 40 && items_sent < 640) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
				repeat (n) send_random_sample();
				send_tick();
				k += n + 1;
				if (items_sent > 560)
					no_gaps = 1'b1;
			end
		end

		while (sb.pending() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
